[rtl/nsts_pkg.sv]
// ----------------------------------------------------------------------------
// nsts_pkg
// Shared types, constants and the quarter-wave sine table of the note
// sequence tone synthesizer.
// ----------------------------------------------------------------------------
`default_nettype none

package nsts_pkg;

  // Table sizes.
  localparam int unsigned MAX_NOTES    = 64;
  localparam int unsigned MAX_TONES    = 4;
  localparam int unsigned SINE_ENTRIES = 1024;

  // Field widths of the item channels.
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned DUR_W      = 24;
  localparam int unsigned TCNT_W     = 3;
  localparam int unsigned INC_W      = 32;
  localparam int unsigned SAMPLE_W   = 15;
  localparam int unsigned NOTE_OUT_W = 6;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned NCOUNT_W   = 7;
  localparam int unsigned RAMP_W     = 16;
  localparam logic [NCOUNT_W-1:0] NCOUNT_RESET = 7'd1;
  localparam logic [RAMP_W-1:0]   RAMP_RESET   = 16'd2400;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NOTE_COUNT = 1'b0,
    CFG_RAMP       = 1'b1
  } cfg_reg_e;

  // Derived widths.
  localparam int unsigned NOTE_BITS = $clog2(MAX_NOTES);
  localparam int unsigned TIDX_W    = $clog2(MAX_TONES);
  localparam int unsigned LEFT_W    = DUR_W + 1;
  localparam int unsigned SINE_BITS = $clog2(SINE_ENTRIES);
  localparam int unsigned QTR_BITS  = SINE_BITS - 2;
  localparam int unsigned QTR_ENTRIES = SINE_ENTRIES / 4;
  localparam int unsigned SUM_W     = SAMPLE_W + TIDX_W;
  localparam int unsigned MAG_W     = SUM_W - 1;
  localparam int unsigned SINE_MAG_W = 14;
  localparam int unsigned AVG_W     = SINE_MAG_W;
  localparam int unsigned DVD_W     = AVG_W + RAMP_W;
  localparam int unsigned QUOT_W    = AVG_W;

  // Average of three tones: multiply by ceil(2^17 / 3), keep the top bits.
  localparam int unsigned     RECIP3_SHIFT = 17;
  localparam logic [INC_W-1:0] RECIP3      = 32'd43691;

  // One note table entry.
  typedef struct packed {
    logic [MAX_TONES-1:0][INC_W-1:0] inc;
    logic [TCNT_W-1:0]               tone_count;
    logic [DUR_W-1:0]                duration;
  } note_entry_t;

  localparam int unsigned ENTRY_W = $bits(note_entry_t);

  // Sine generation in Q30 fixed point, evaluated at elaboration only.
  localparam logic [63:0] AMPLITUDE  = 64'd16000;
  localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam logic [7:0]  SINE_DENS [6] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};

  typedef logic [QTR_ENTRIES-1:0][SINE_MAG_W-1:0] sine_rom_t;

  // Magnitude of the sine for a quarter-wave position q in 0..QTR_ENTRIES.
  function automatic logic [SINE_MAG_W-1:0] sine_mag(input int unsigned q);
    logic [63:0] g;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] s;
    logic [63:0] v;
    g  = 64'(q) << (32 - SINE_BITS);
    x  = (g * TWO_PI_Q30) >> 32;
    x2 = (x * x) >> 30;
    term = Q30_ONE;
    for (int k = 0; k < 6; k++) begin
      term = Q30_ONE - (((x2 * term) >> 30) / 64'(SINE_DENS[k]));
    end
    s = (x * term) >> 30;
    v = (s * AMPLITUDE + (64'd1 << 20)) >> 30;
    if (v > AMPLITUDE) begin
      v = AMPLITUDE;
    end
    return SINE_MAG_W'(v);
  endfunction

  function automatic sine_rom_t sine_rom_build();
    sine_rom_t rom;
    for (int q = 0; q < QTR_ENTRIES; q++) begin
      rom[q] = sine_mag(q);
    end
    return rom;
  endfunction

  localparam sine_rom_t               SINE_ROM  = sine_rom_build();
  localparam logic [SINE_MAG_W-1:0]   SINE_PEAK = sine_mag(QTR_ENTRIES);

  // Tick sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_ENTRY,
    S_NUM,
    S_MUL,
    S_LOOK,
    S_AVG,
    S_SCALE,
    S_DIV,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

[rtl/nsts_ram.sv]
// ----------------------------------------------------------------------------
// nsts_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module nsts_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 64,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/nsts_div.sv]
// ----------------------------------------------------------------------------
// nsts_div
// Restoring divider, one quotient bit per cycle, for the envelope scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module nsts_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [nsts_pkg::DVD_W-1:0]   dividend_i,
  input  logic [nsts_pkg::RAMP_W-1:0]  divisor_i,
  output logic                         done_o,
  output logic [nsts_pkg::QUOT_W-1:0]  quot_o
);

  import nsts_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUOT_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [RAMP_W-1:0] rem_q, rem_d;
  logic [QUOT_W-1:0] qd_q, qd_d;
  logic [RAMP_W-1:0] dvs_q, dvs_d;
  logic [RAMP_W:0]   partial;
  logic [RAMP_W:0]   trial;
  logic              fits;

  // The quotient is known to stay below 2^QUOT_W, so the upper dividend
  // bits start below the divisor and only QUOT_W steps are needed.
  assign partial = {rem_q, qd_q[QUOT_W-1]};
  assign trial   = partial - {1'b0, dvs_q};
  assign fits    = partial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    qd_d   = qd_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = dividend_i[DVD_W-1:QUOT_W];
      qd_d   = dividend_i[QUOT_W-1:0];
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? trial[RAMP_W-1:0] : partial[RAMP_W-1:0];
      qd_d  = {qd_q[QUOT_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(QUOT_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    qd_q  <= qd_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = qd_q;

endmodule

`default_nettype wire

[rtl/note_sequence_tone_synth.sv]
// ----------------------------------------------------------------------------
// note_sequence_tone_synth
// Additive sine tone sequencer with a linear attack and release envelope.
// ----------------------------------------------------------------------------
// A load item (kind 0) writes one note table entry in the cycle it is
// transferred and returns no result. A tick item (kind 1) returns one
// sample: one shared 32x32 multiplier forms each tone phase, followed by
// the sine lookup of that tone, and then the average and the envelope
// product, and a divider that makes one quotient bit per cycle scales by
// the ramp length. A note without tones skips the multiplier and the
// divider. The input is not ready while a tick is in work; the result sits
// in an output register, so the next item may be transferred while it
// waits. The note table needs no clearing pass: entries that were never
// loaded must not be played.
`default_nettype none

module note_sequence_tone_synth (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration writes.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [nsts_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [nsts_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Input items.
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                kind_i,
  input  logic [nsts_pkg::SLOT_W-1:0]         note_slot_i,
  input  logic [nsts_pkg::DUR_W-1:0]          note_duration_i,
  input  logic [nsts_pkg::TCNT_W-1:0]         tone_count_i,
  input  logic [nsts_pkg::INC_W-1:0]          tone_increment_0_i,
  input  logic [nsts_pkg::INC_W-1:0]          tone_increment_1_i,
  input  logic [nsts_pkg::INC_W-1:0]          tone_increment_2_i,
  input  logic [nsts_pkg::INC_W-1:0]          tone_increment_3_i,
  // Result items.
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [nsts_pkg::SAMPLE_W-1:0] sample_o,
  output logic [nsts_pkg::NOTE_OUT_W-1:0]     playing_note_o
);

  import nsts_pkg::*;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_e                 state_q, state_d;
  logic [NCOUNT_W-1:0]    ncount_q, ncount_d;
  logic [RAMP_W-1:0]      ramp_q, ramp_d;
  logic [NOTE_BITS-1:0]   cur_q, cur_d;
  logic [LEFT_W-1:0]      left_q, left_d;
  logic [INC_W-1:0]       counter_q, counter_d;
  logic [RAMP_W-1:0]      num_q, num_d;
  logic [TIDX_W-1:0]      tone_q, tone_d;
  logic [SUM_W-1:0]       acc_q, acc_d;
  logic [INC_W-1:0]       prod_q, prod_d;
  logic                   sign_q, sign_d;
  logic                   silent_q, silent_d;
  logic                   out_valid_q, out_valid_d;
  logic [SAMPLE_W-1:0]    sample_q, sample_d;
  logic [NOTE_OUT_W-1:0]  note_q, note_d;

  // --------------------------------------------------------------------------
  // Note table
  // --------------------------------------------------------------------------
  logic                  tick_xfer;
  logic                  load_xfer;
  logic                  tbl_we;
  logic [NOTE_BITS-1:0]  tbl_raddr;
  logic [ENTRY_W-1:0]    tbl_rdata;
  note_entry_t           wentry;
  note_entry_t           entry;

  assign in_ready_o = (state_q == S_IDLE);
  assign tick_xfer  = in_valid_i && in_ready_o && kind_i;
  assign load_xfer  = in_valid_i && in_ready_o && !kind_i;
  assign tbl_we     = load_xfer && (32'(note_slot_i) < MAX_NOTES);

  // Build the entry of a load; the tone count saturates.
  always_comb begin
    wentry.duration   = note_duration_i;
    wentry.tone_count = (32'(tone_count_i) > MAX_TONES) ? TCNT_W'(MAX_TONES)
                                                         : tone_count_i;
    wentry.inc[0] = tone_increment_0_i;
    wentry.inc[1] = tone_increment_1_i;
    wentry.inc[2] = tone_increment_2_i;
    wentry.inc[3] = tone_increment_3_i;
  end

  assign entry = note_entry_t'(tbl_rdata);

  nsts_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_NOTES)
  ) u_note_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (NOTE_BITS'(note_slot_i)),
    .wdata_i (ENTRY_W'(wentry)),
    .re_i    (tick_xfer),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // --------------------------------------------------------------------------
  // Note advance on a tick transfer
  // --------------------------------------------------------------------------
  logic [NCOUNT_W-1:0]  count_eff;
  logic [NCOUNT_W-1:0]  cur_inc;
  logic [NOTE_BITS-1:0] cur_next;
  logic                 advance;

  always_comb begin
    if (ncount_q == '0) begin
      count_eff = NCOUNT_W'(1);
    end else if (32'(ncount_q) > MAX_NOTES) begin
      count_eff = NCOUNT_W'(MAX_NOTES);
    end else begin
      count_eff = ncount_q;
    end
  end

  assign cur_inc   = NCOUNT_W'(cur_q) + 1'b1;
  assign cur_next  = (cur_inc >= count_eff) ? '0 : NOTE_BITS'(cur_inc);
  assign advance   = (left_q == '0);
  assign tbl_raddr = advance ? cur_next : cur_q;

  // --------------------------------------------------------------------------
  // Countdown and envelope numerator
  // --------------------------------------------------------------------------
  logic [RAMP_W-1:0] ramp_eff;
  logic [LEFT_W-1:0] left_load;
  logic [LEFT_W-1:0] left_dec;
  logic [DUR_W-1:0]  elapsed;
  logic [RAMP_W-1:0] num_calc;

  assign ramp_eff  = (ramp_q == '0) ? RAMP_W'(1) : ramp_q;
  assign left_load = (left_q == '0) ? LEFT_W'(entry.duration) : left_q;
  assign left_dec  = (left_load == '0) ? '0 : left_load - 1'b1;

  // Elapsed time is zero when the entry was shortened under a playing note.
  assign elapsed = (left_q > LEFT_W'(entry.duration)) ? '0
                 : entry.duration - DUR_W'(left_q);

  always_comb begin
    if (left_q <= LEFT_W'(ramp_eff)) begin
      num_calc = RAMP_W'(left_q);
    end else if (elapsed <= DUR_W'(ramp_eff)) begin
      num_calc = RAMP_W'(elapsed);
    end else begin
      num_calc = ramp_eff;
    end
  end

  // --------------------------------------------------------------------------
  // Quarter-wave sine lookup from the top phase bits
  // --------------------------------------------------------------------------
  logic [SINE_BITS-1:0]  sidx;
  logic                  sine_neg;
  logic                  sine_upper;
  logic [QTR_BITS-1:0]   sine_low;
  logic [QTR_BITS-1:0]   sine_low_neg;
  logic [SINE_MAG_W-1:0] sine_val;

  assign sidx         = prod_q[INC_W-1 -: SINE_BITS];
  assign sine_neg     = sidx[SINE_BITS-1];
  assign sine_upper   = sidx[SINE_BITS-2];
  assign sine_low     = sidx[QTR_BITS-1:0];
  assign sine_low_neg = -sine_low;

  always_comb begin
    if (!sine_upper) begin
      sine_val = SINE_ROM[sine_low];
    end else if (sine_low == '0) begin
      sine_val = SINE_PEAK;
    end else begin
      sine_val = SINE_ROM[sine_low_neg];
    end
  end

  // --------------------------------------------------------------------------
  // Shared multiplier
  // --------------------------------------------------------------------------
  logic [INC_W-1:0] mul_a;
  logic [INC_W-1:0] mul_b;
  logic [INC_W-1:0] mul_lo;
  logic [MAG_W-1:0] sum_mag;
  logic [AVG_W-1:0] avg;

  assign sum_mag = acc_q[SUM_W-1] ? MAG_W'(-acc_q) : MAG_W'(acc_q);

  // Average over the tone count; three tones use the reciprocal product.
  always_comb begin
    case (entry.tone_count)
      TCNT_W'(1): avg = AVG_W'(sum_mag);
      TCNT_W'(2): avg = AVG_W'(sum_mag >> 1);
      TCNT_W'(3): avg = AVG_W'(prod_q >> RECIP3_SHIFT);
      default:    avg = AVG_W'(sum_mag >> 2);
    endcase
  end

  always_comb begin
    unique case (state_q)
      S_MUL: begin
        mul_a = counter_q;
        mul_b = entry.inc[tone_q];
      end
      S_AVG: begin
        mul_a = INC_W'(sum_mag);
        mul_b = RECIP3;
      end
      S_SCALE: begin
        mul_a = INC_W'(avg);
        mul_b = INC_W'(num_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_lo = INC_W'(mul_a * mul_b);

  // --------------------------------------------------------------------------
  // Envelope divider
  // --------------------------------------------------------------------------
  logic              div_start;
  logic              div_done;
  logic [QUOT_W-1:0] div_quot;

  assign div_start = (state_q == S_SCALE);

  nsts_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mul_lo[DVD_W-1:0]),
    .divisor_i  (ramp_eff),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] quot_ext;

  assign quot_ext = SAMPLE_W'(div_quot);

  always_comb begin
    state_d     = state_q;
    ncount_d    = ncount_q;
    ramp_d      = ramp_q;
    cur_d       = cur_q;
    left_d      = left_q;
    counter_d   = counter_q;
    num_d       = num_q;
    tone_d      = tone_q;
    acc_d       = acc_q;
    prod_d      = prod_q;
    sign_d      = sign_q;
    silent_d    = silent_q;
    out_valid_d = out_valid_q;
    sample_d    = sample_q;
    note_d      = note_q;

    // Configuration register writes.
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_NOTE_COUNT: ncount_d = cfg_data_i[NCOUNT_W-1:0];
        CFG_RAMP:       ramp_d   = cfg_data_i[RAMP_W-1:0];
      endcase
    end

    // The output register empties on a result transfer.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (tick_xfer) begin
          if (advance) begin
            cur_d = cur_next;
          end
          state_d = S_ENTRY;
        end
      end
      S_ENTRY: begin
        left_d = left_dec;
        tone_d = '0;
        acc_d  = '0;
        state_d = S_NUM;
      end
      S_NUM: begin
        num_d    = num_calc;
        silent_d = (entry.tone_count == '0);
        state_d  = (entry.tone_count == '0) ? S_DONE : S_MUL;
      end
      S_MUL: begin
        prod_d  = mul_lo;
        state_d = S_LOOK;
      end
      S_LOOK: begin
        acc_d  = sine_neg ? acc_q - SUM_W'(sine_val) : acc_q + SUM_W'(sine_val);
        tone_d = tone_q + 1'b1;
        if (TCNT_W'(tone_q) + 1'b1 == entry.tone_count) begin
          state_d = S_AVG;
        end else begin
          state_d = S_MUL;
        end
      end
      S_AVG: begin
        prod_d  = mul_lo;
        sign_d  = acc_q[SUM_W-1];
        state_d = S_SCALE;
      end
      S_SCALE: begin
        counter_d = counter_q + 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          note_d      = NOTE_OUT_W'(cur_q);
          if (silent_q) begin
            sample_d = '0;
          end else begin
            sample_d = sign_q ? -quot_ext : quot_ext;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ncount_q    <= NCOUNT_RESET;
      ramp_q      <= RAMP_RESET;
      cur_q       <= '0;
      left_q      <= '0;
      counter_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ncount_q    <= ncount_d;
      ramp_q      <= ramp_d;
      cur_q       <= cur_d;
      left_q      <= left_d;
      counter_q   <= counter_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    num_q    <= num_d;
    tone_q   <= tone_d;
    acc_q    <= acc_d;
    prod_q   <= prod_d;
    sign_q   <= sign_d;
    silent_q <= silent_d;
    sample_q <= sample_d;
    note_q   <= note_d;
  end

  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign sample_o       = sample_q;
  assign playing_note_o = note_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef ASSERT_OFF
  // A tick transfer always starts the sequencer on the table read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_xfer |=> state_q == S_ENTRY)
    else $error("tick transfer did not start the sequencer");

  // The divider only finishes while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside of its wait state");

  // The enveloped magnitude never exceeds the sine amplitude.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> 64'(div_quot) <= AMPLITUDE)
    else $error("envelope quotient out of range");
`endif

endmodule

`default_nettype wire

[sim/tb_note_sequence_tone_synth.sv]
// ----------------------------------------------------------------------------
// tb_note_sequence_tone_synth
// Self-checking testbench of the note sequence tone synthesizer. A queue of
// note loads and sample ticks feeds a valid/ready driver. Every tick transfer
// runs through a cycle-free model of the sequencer, the sine sum and the
// envelope. Every sample transfer is compared with the oldest expected sample.
// Both sides idle at random, and one long output hold-off backs up the block.
// ----------------------------------------------------------------------------
module tb_note_sequence_tone_synth;
  timeunit 1ns;
  timeprecision 1ps;

  import nsts_pkg::*;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Fixed-point sine generation, Q30.
  localparam logic [63:0] Q30_UNIT   = 64'd1 << 30;
  localparam logic [63:0] TWO_PI_FIX = 64'd6746518852;
  localparam logic [63:0] FULL_SCALE = 64'd16000;
  localparam logic [63:0] TAYLOR_DENS [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

  // Leave margin after the last sample before idle writes.
  localparam int unsigned SETTLE_CYCLES = 40;

  typedef struct packed {
    logic                            kind;
    logic [SLOT_W-1:0]               slot;
    logic [DUR_W-1:0]                duration;
    logic [TCNT_W-1:0]               tones;
    logic [MAX_TONES-1:0][INC_W-1:0] inc;
  } synth_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0]   sample;
    logic [NOTE_OUT_W-1:0] note;
  } sample_rec_t;

  // Block ports; the inputs are driven to known values from time zero.
  logic                         clk_i              = 1'b0;
  logic                         rst_ni             = 1'b0;
  logic                         cfg_valid_i        = 1'b0;
  logic                         cfg_ready_o;
  logic [CFG_IDX_W-1:0]         cfg_index_i        = CFG_NOTE_COUNT;
  logic [CFG_DATA_W-1:0]        cfg_data_i         = '0;
  logic                         in_valid_i         = 1'b0;
  logic                         in_ready_o;
  logic                         kind_i             = KIND_LOAD;
  logic [SLOT_W-1:0]            note_slot_i        = '0;
  logic [DUR_W-1:0]             note_duration_i    = '0;
  logic [TCNT_W-1:0]            tone_count_i       = '0;
  logic [INC_W-1:0]             tone_increment_0_i = '0;
  logic [INC_W-1:0]             tone_increment_1_i = '0;
  logic [INC_W-1:0]             tone_increment_2_i = '0;
  logic [INC_W-1:0]             tone_increment_3_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i        = 1'b0;
  logic signed [SAMPLE_W-1:0]   sample_o;
  logic [NOTE_OUT_W-1:0]        playing_note_o;

  note_sequence_tone_synth DUT (.*);

  // Model state of the synthesizer.
  logic [DUR_W-1:0]  note_dur   [MAX_NOTES] = '{default: '0};
  int unsigned       note_tones [MAX_NOTES] = '{default: 0};
  logic [INC_W-1:0]  note_inc   [MAX_NOTES][MAX_TONES];
  int unsigned       play_note    = 0;
  int unsigned       left_samples = 0;
  logic [31:0]       phase_ctr    = '0;
  logic [NCOUNT_W-1:0] reg_notes  = NCOUNT_RESET;
  logic [RAMP_W-1:0]   reg_ramp   = RAMP_RESET;
  int                sine_lut   [SINE_ENTRIES];

  synth_item_t items_to_send [$];
  sample_rec_t expected_samples [$];
  synth_item_t item_on_bus;

  int unsigned send_gap  = 0;
  int unsigned recv_stall = 0;
  int unsigned hold_left = 0;
  logic        hold_armed = 1'b1;
  int unsigned samples_seen = 0;
  int unsigned mismatches = 0;
  logic        no_gaps = 1'b0;

  // Stimulus bookkeeping: played range and slots holding very long notes.
  int unsigned live_count = 1;
  logic        long_note [MAX_NOTES] = '{default: 1'b0};

  // Clock.
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // One full-wave sine table entry scaled to plus or minus 16000.
  function automatic int sine_value(input int unsigned i);
    logic [63:0] g;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] s;
    logic [63:0] v;
    logic        neg;
    g   = (64'(i) << 32) / 64'(SINE_ENTRIES);
    neg = 1'b0;
    if (g >= 64'h8000_0000) begin
      neg = 1'b1;
      g   = g - 64'h8000_0000;
    end
    if (g > 64'h4000_0000) begin
      g = 64'h8000_0000 - g;
    end
    x    = (g * TWO_PI_FIX) >> 32;
    x2   = (x * x) >> 30;
    term = Q30_UNIT;
    for (int k = 0; k < 6; k++) begin
      term = Q30_UNIT - (((x2 * term) >> 30) / TAYLOR_DENS[k]);
    end
    s = (x * term) >> 30;
    v = (s * FULL_SCALE + (64'd1 << 20)) >> 30;
    if (v > FULL_SCALE) begin
      v = FULL_SCALE;
    end
    return neg ? -int'(v) : int'(v);
  endfunction

  // Apply one transferred item to the model; ticks queue one expected sample.
  task automatic apply_item(input synth_item_t it);
    int unsigned cnt;
    int unsigned ramp;
    int unsigned r;
    int unsigned d;
    int unsigned num;
    int unsigned n;
    int unsigned el;
    longint      acc;
    logic [31:0] phase;
    sample_rec_t rec;
    if (it.kind == KIND_LOAD) begin
      note_dur[it.slot]   = it.duration;
      note_tones[it.slot] = (it.tones > MAX_TONES) ? MAX_TONES : it.tones;
      for (int j = 0; j < MAX_TONES; j++) begin
        note_inc[it.slot][j] = it.inc[j];
      end
    end else begin
      cnt  = (reg_notes == 0) ? 1 : ((reg_notes > MAX_NOTES) ? MAX_NOTES : reg_notes);
      ramp = (reg_ramp == 0) ? 1 : reg_ramp;
      // Advance to the next note once the current one has run out.
      if (left_samples == 0) begin
        play_note++;
        if (play_note >= cnt) begin
          play_note = 0;
        end
        left_samples = note_dur[play_note];
      end
      if (left_samples > 0) begin
        left_samples--;
      end
      // Envelope numerator: release, then attack, then sustain.
      r = left_samples;
      d = note_dur[play_note];
      if (r <= ramp) begin
        num = r;
      end else begin
        el  = (r > d) ? 0 : d - r;
        num = (el <= ramp) ? el : ramp;
      end
      n   = note_tones[play_note];
      acc = 0;
      if (n != 0) begin
        for (int j = 0; j < n; j++) begin
          phase = phase_ctr * note_inc[play_note][j];
          acc   = acc + sine_lut[phase[31 -: SINE_BITS]];
        end
        acc = acc / longint'(n);
        acc = acc * longint'(num) / longint'(ramp);
        phase_ctr++;
      end
      rec.sample = acc[SAMPLE_W-1:0];
      rec.note   = play_note[NOTE_OUT_W-1:0];
      expected_samples.push_back(rec);
    end
  endtask

  // Driver: one transfer per handshake, random gap before each next item.
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned gap;
    synth_item_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap   <= 0;
    end else begin
      gap = send_gap;
      if (in_valid_i && in_ready_o) begin
        apply_item(item_on_bus);
        gap = no_gaps ? 0 : $urandom_range(0, 11);
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap != 0) begin
          gap--;
          in_valid_i <= 1'b0;
        end else if (items_to_send.size() != 0) begin
          nxt                = items_to_send.pop_front();
          item_on_bus        = nxt;
          in_valid_i         <= 1'b1;
          kind_i             <= nxt.kind;
          note_slot_i        <= nxt.slot;
          note_duration_i    <= nxt.duration;
          tone_count_i       <= nxt.tones;
          tone_increment_0_i <= nxt.inc[0];
          tone_increment_1_i <= nxt.inc[1];
          tone_increment_2_i <= nxt.inc[2];
          tone_increment_3_i <= nxt.inc[3];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      send_gap <= gap;
    end
  end

  // Monitor: compare each sample transfer with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned stall;
    sample_rec_t want;
    if (!rst_ni) begin
      out_ready_i  <= 1'b0;
      recv_stall   <= 0;
      samples_seen <= 0;
    end else begin
      stall = recv_stall;
      if (out_valid_o && out_ready_i) begin
        samples_seen <= samples_seen + 1;
        if (expected_samples.size() == 0) begin
          mismatches++;
          $display("%0t: sample %0d on note %0d with no tick outstanding",
                   $time, sample_o, playing_note_o);
        end else begin
          want = expected_samples.pop_front();
          if (sample_o !== want.sample) begin
            mismatches++;
            $display("%0t: sample expected %0d actual %0d", $time,
                     $signed(want.sample), sample_o);
          end
          if (playing_note_o !== want.note) begin
            mismatches++;
            $display("%0t: playing_note expected %0d actual %0d", $time,
                     want.note, playing_note_o);
          end
        end
        stall = no_gaps ? 0 : $urandom_range(0, 11);
      end else if (stall != 0) begin
        stall--;
      end
      recv_stall  <= stall;
      out_ready_i <= (stall == 0) && (hold_left == 0);
    end
  end

  // One long output hold-off so that the block stalls its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left  <= 0;
      hold_armed <= 1'b1;
    end else if (hold_armed && samples_seen == 300) begin
      hold_left  <= 400;
      hold_armed <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic push_load(input int unsigned slot, input logic [DUR_W-1:0] dur,
                           input logic [TCNT_W-1:0] tones, input logic [INC_W-1:0] i0,
                           input logic [INC_W-1:0] i1, input logic [INC_W-1:0] i2,
                           input logic [INC_W-1:0] i3);
    synth_item_t it;
    it.kind     = KIND_LOAD;
    it.slot     = SLOT_W'(slot);
    it.duration = dur;
    it.tones    = tones;
    it.inc      = {i3, i2, i1, i0};
    items_to_send.push_back(it);
  endtask

  // Tick with random content in the fields that a tick does not use.
  task automatic push_tick();
    synth_item_t it;
    it.kind     = KIND_TICK;
    it.slot     = SLOT_W'($urandom);
    it.duration = DUR_W'($urandom);
    it.tones    = TCNT_W'($urandom);
    for (int j = 0; j < MAX_TONES; j++) begin
      it.inc[j] = $urandom;
    end
    items_to_send.push_back(it);
  endtask

  // Wait until every item is transferred and every sample has come back.
  // The state is polled between clock edges so that no update is missed.
  task automatic wait_idle();
    while (items_to_send.size() != 0 || in_valid_i || expected_samples.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write both registers back to back; called at a clock edge while idle.
  task automatic set_config(input logic [CFG_DATA_W-1:0] notes_word,
                            input logic [CFG_DATA_W-1:0] ramp_word);
    logic [NCOUNT_W-1:0] v;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_NOTE_COUNT;
    cfg_data_i  <= notes_word;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    reg_notes   = notes_word[NCOUNT_W-1:0];
    cfg_index_i <= CFG_RAMP;
    cfg_data_i  <= ramp_word;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    reg_ramp    = ramp_word;
    cfg_valid_i <= 1'b0;
    v          = notes_word[NCOUNT_W-1:0];
    live_count = (v == 0) ? 1 : ((v > MAX_NOTES) ? MAX_NOTES : v);
  endtask

  // One random phase: new settings, then a mix of loads and ticks.
  task automatic run_phase(input logic [CFG_DATA_W-1:0] notes_word,
                           input logic [CFG_DATA_W-1:0] ramp_word,
                           input logic quiet, input int unsigned n_items);
    int unsigned slot;
    logic [DUR_W-1:0] dur;
    wait_idle();
    no_gaps <= quiet;
    set_config(notes_word, ramp_word);
    // Very long notes may only sit outside the range that is played.
    for (int s = 0; s < live_count; s++) begin
      if (long_note[s]) begin
        push_load(s, DUR_W'($urandom_range(0, 40)), TCNT_W'($urandom_range(0, 7)),
                  $urandom, $urandom, $urandom, $urandom);
        long_note[s] = 1'b0;
      end
    end
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 99) < 25) begin
        slot = $urandom_range(0, 1) ? $urandom_range(0, live_count - 1)
                                    : $urandom_range(0, MAX_NOTES - 1);
        if (slot >= live_count && $urandom_range(0, 2) == 0) begin
          dur             = DUR_W'($urandom);
          long_note[slot] = 1'b1;
        end else begin
          dur             = DUR_W'($urandom_range(0, 40));
          long_note[slot] = 1'b0;
        end
        push_load(slot, dur, TCNT_W'($urandom_range(0, 7)), $urandom, $urandom, $urandom,
                  $urandom);
      end else begin
        push_tick();
      end
    end
  endtask

  // Stimulus and end of run.
  initial begin
    for (int i = 0; i < SINE_ENTRIES; i++) begin
      sine_lut[i] = sine_value(i);
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: full-scale and zero increments, a note without tones, a zero
    // duration, a saturating tone count, three tones and a maximum duration.
    push_load(0, 5, 4, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h4000_0000);
    push_load(1, 0, 0, 32'h0, 32'h0, 32'h0, 32'h0);
    push_load(2, 1, 7, 32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210);
    push_load(3, 30, 3, 32'h0100_0000, 32'h0234_5678, 32'h00F0_0000, 32'hFFFF_FFFF);
    push_load(63, 24'hFF_FFFF, 2, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0, 32'h0);
    long_note[63] = 1'b1;
    wait_idle();
    // With two notes the first tick after reset plays entry 1.
    set_config(16'd2, RAMP_RESET);
    repeat (3) push_tick();
    wait_idle();
    set_config(16'd4, 16'd1);
    repeat (8) push_tick();
    // Shorten the note being played, below the count still left.
    push_load(3, 2, 3, 32'h0100_0000, 32'h0234_5678, 32'h00F0_0000, 32'hFFFF_FFFF);
    repeat (3) push_tick();

    // Fill the whole table so that any note count may be played.
    for (int s = 0; s < MAX_NOTES; s++) begin
      push_load(s, DUR_W'($urandom_range(0, 40)), TCNT_W'($urandom_range(0, 7)),
                $urandom, $urandom, $urandom, $urandom);
      long_note[s] = 1'b0;
    end

    run_phase(16'h0000, 16'd0, 1'b0, 110);
    run_phase(16'd64, 16'hFFFF, 1'b1, 110);
    run_phase(16'd127, 16'd3, 1'b0, 110);
    run_phase(16'd5, CFG_DATA_W'($urandom_range(1, 20)), 1'b0, 110);
    run_phase(16'hFFC0, 16'd1, 1'b1, 110);
    run_phase(CFG_DATA_W'($urandom_range(1, 64)), CFG_DATA_W'($urandom_range(1, 40)),
              1'b0, 110);
    run_phase(16'd2, 16'd2400, 1'b0, 110);
    run_phase(16'd1, 16'd8, 1'b0, 110);

    wait_idle();
    if (mismatches == 0) begin
      $display("tb_note_sequence_tone_synth: PASS");
    end else begin
      $display("tb_note_sequence_tone_synth: FAIL");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #1_000_000;
    $display("tb_note_sequence_tone_synth: FAIL");
    $finish;
  end

endmodule
